### hdl/gsgd_pkg.sv
// Package for the gyro swing gesture detector: sample and control types,
// move and gesture codes, sizes and the magnitude helper.
// No dependencies.
package gsgd_pkg;

   localparam int WINDOW = 8;
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   localparam int RATE_W = 16;
   localparam int THR_W  = 15;
   localparam int GEST_W = 3;

   localparam logic [THR_W-1:0] DOWN_THR_RESET = 15'd14400; // 900 deg/s
   localparam logic [THR_W-1:0] SIDE_THR_RESET = 15'd8000;  // 500 deg/s

   typedef enum logic {
      CSR_DOWN_THRESHOLD = 1'b0,
      CSR_SIDE_THRESHOLD = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      MOVE_NONE  = 2'd0,
      MOVE_DOWN  = 2'd1,
      MOVE_LEFT  = 2'd2,
      MOVE_RIGHT = 2'd3
   } move_type;

   typedef enum logic [GEST_W-1:0] {
      GEST_DOWN          = 3'd0,
      GEST_LEFT          = 3'd1,
      GEST_RIGHT         = 3'd2,
      GEST_DOUBLE_CENTER = 3'd3,
      GEST_LEFT_RIGHT    = 3'd4
   } gesture_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_DONE = 2'd2
   } state_type;

   typedef struct packed {
      logic signed [RATE_W-1:0] pitch;
      logic signed [RATE_W-1:0] yaw;
   } sample_type;

   typedef struct packed {
      logic rotate;
      logic load;
   } cell_ctl_type;

   typedef struct packed {
      logic clear;
      logic update;
   } peak_ctl_type;

   function automatic logic [RATE_W-1:0] mag(input logic signed [RATE_W-1:0] v);
      logic [RATE_W-1:0] r;
      r = v[RATE_W-1] ? RATE_W'(-v) : RATE_W'(v);
      return r;
   endfunction

endpackage

### hdl/gsgd_cell.sv
// One ring cell: holds one pitch/yaw sample pair, takes its neighbor's pair
// on rotate or a new sample on load. Depends on gsgd_pkg.
module gsgd_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  gsgd_pkg::cell_ctl_type ctl,
   input  gsgd_pkg::sample_type  nbr,
   input  gsgd_pkg::sample_type  new_sample,
   output gsgd_pkg::sample_type  data
);

   gsgd_pkg::sample_type data_ff, data_in;

   always_comb begin
      priority if (ctl.load) begin
         data_in = new_sample;
      end else if (ctl.rotate) begin
         data_in = nbr;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

### hdl/gsgd_peak.sv
// Peak tracker: keeps the signed peak per axis over the samples streamed out
// of the cell ring; first sample wins on equal magnitude. Depends on gsgd_pkg.
module gsgd_peak (
   input  logic                   clock,
   input  logic                   reset,
   input  gsgd_pkg::peak_ctl_type ctl,
   input  gsgd_pkg::sample_type   sample,
   output gsgd_pkg::sample_type   peak
);

   gsgd_pkg::sample_type peak_ff, peak_in;

   always_comb begin
      peak_in = peak_ff;
      if (ctl.clear) begin
         peak_in = '0;
      end else if (ctl.update) begin
         if (gsgd_pkg::mag(sample.pitch) > gsgd_pkg::mag(peak_ff.pitch)) begin
            peak_in.pitch = sample.pitch;
         end
         if (gsgd_pkg::mag(sample.yaw) > gsgd_pkg::mag(peak_ff.yaw)) begin
            peak_in.yaw = sample.yaw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
      end else begin
         peak_ff <= peak_in;
      end
   end

   assign peak = peak_ff;

endmodule

### hdl/gyro_swing_gesture_detector.sv
// Gyro swing gesture detector, top level.
// Depends on gsgd_pkg, gsgd_cell and gsgd_peak.
//
// Usage:
//   req_* carries one gyro sample per transfer: pitch and yaw rate (signed
//   Q12.4 deg/s) and the double-gesture button flag. rsp_gesture carries a
//   gesture code (0 down, 1 left, 2 right, 3 double center, 4 left plus
//   right) at the end of a swing; most samples produce no transfer at all.
//   csr_* writes the down (index 0) and side (index 1) thresholds; write
//   them only while the block is idle.
// Sequence:
//   A sample is captured, then the ring of cells is rotated once past the
//   peak tracker, then the classify step emits any finished gesture and
//   writes the sample into its slot. req_stall is high from the rotation
//   until the classify step commits, so no new sample is taken before then.
//   A gesture appears on rsp_* the cycle after the classify step.
// Reset (synchronous, active high):
//   Clears the ring to zero, the write slot, the pending move, the output
//   valid flag, and restores thresholds to 900 and 500 deg/s.
// Back-pressure:
//   A finished gesture waits in the output register while rsp_stall is
//   high; the next sample is still taken and scanned, and only holds in its
//   classify step if it must emit while the earlier gesture is still held.
module gyro_swing_gesture_detector (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [gsgd_pkg::RATE_W-1:0]   req_pitch_rate,
   input  logic signed [gsgd_pkg::RATE_W-1:0]   req_yaw_rate,
   input  logic                                 req_double_held,
   // gesture channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [gsgd_pkg::GEST_W-1:0]          rsp_gesture,
   // threshold registers
   input  logic                                 csr_wr_en,
   input  logic                                 csr_index,
   input  logic [gsgd_pkg::THR_W-1:0]           csr_wdata
);

   localparam int W  = gsgd_pkg::WINDOW;
   localparam int SW = gsgd_pkg::SLOT_W;

   // control state
   gsgd_pkg::state_type         state_ff, state_in;
   logic [SW-1:0]               scan_cnt_ff, scan_cnt_in;
   logic [SW-1:0]               write_slot_ff, write_slot_in;
   gsgd_pkg::move_type          pending_ff, pending_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [gsgd_pkg::THR_W-1:0]  down_thr_ff, side_thr_ff;

   // payload
   gsgd_pkg::sample_type        sample_ff, sample_in;
   logic                        dbl_ff, dbl_in;
   gsgd_pkg::gesture_type       gesture_ff, gesture_in;

   // ring and peak tracker
   gsgd_pkg::cell_ctl_type      cell_ctl [W];
   gsgd_pkg::sample_type        cell_q   [W];
   gsgd_pkg::peak_ctl_type      peak_ctl;
   gsgd_pkg::sample_type        peak;

   // classify step
   logic [gsgd_pkg::RATE_W-1:0] pmag, ymag;
   gsgd_pkg::move_type          move_cls;
   logic                        emit;
   gsgd_pkg::gesture_type       code;
   logic                        commit;

   // ------------------------------------------------------------------
   // Ring of cells: cell k takes cell k+1 on rotate, so cell 0 presents
   // entries 0..WINDOW-1 in order and WINDOW rotations restore the ring.
   // ------------------------------------------------------------------
   for (genvar k = 0; k < W; k++) begin : g_ring
      localparam int NXT = (k + 1) % W;
      assign cell_ctl[k].rotate = (state_ff == gsgd_pkg::ST_SCAN);
      assign cell_ctl[k].load   = commit && (write_slot_ff == SW'(k));
      gsgd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[k]),
         .nbr        (cell_q[NXT]),
         .new_sample (sample_ff),
         .data       (cell_q[k])
      );
   end

   assign peak_ctl.clear  = (state_ff == gsgd_pkg::ST_IDLE);
   assign peak_ctl.update = (state_ff == gsgd_pkg::ST_SCAN);

   gsgd_peak u_peak (
      .clock  (clock),
      .reset  (reset),
      .ctl    (peak_ctl),
      .sample (cell_q[0]),
      .peak   (peak)
   );

   // ------------------------------------------------------------------
   // Classification on the finished peaks.
   // ------------------------------------------------------------------
   always_comb begin
      pmag     = gsgd_pkg::mag(peak.pitch);
      ymag     = gsgd_pkg::mag(peak.yaw);
      move_cls = pending_ff;
      emit     = 1'b0;
      if ((pmag > ymag) &&
          ($signed({peak.pitch[gsgd_pkg::RATE_W-1], peak.pitch}) >
           $signed({2'b00, down_thr_ff}))) begin
         move_cls = gsgd_pkg::MOVE_DOWN;
      end else if (ymag > {1'b0, side_thr_ff}) begin
         if ((peak.yaw > 0) && (pending_ff != gsgd_pkg::MOVE_RIGHT)) begin
            move_cls = gsgd_pkg::MOVE_LEFT;
         end else if (pending_ff != gsgd_pkg::MOVE_LEFT) begin
            move_cls = gsgd_pkg::MOVE_RIGHT;
         end
      end else begin
         // swing is over: report what was pending, then drop it
         emit     = (pending_ff != gsgd_pkg::MOVE_NONE);
         move_cls = gsgd_pkg::MOVE_NONE;
      end
   end

   always_comb begin
      unique case (pending_ff)
         gsgd_pkg::MOVE_DOWN:
            code = dbl_ff ? gsgd_pkg::GEST_DOUBLE_CENTER : gsgd_pkg::GEST_DOWN;
         gsgd_pkg::MOVE_LEFT:
            code = dbl_ff ? gsgd_pkg::GEST_LEFT_RIGHT : gsgd_pkg::GEST_LEFT;
         gsgd_pkg::MOVE_RIGHT:
            code = dbl_ff ? gsgd_pkg::GEST_LEFT_RIGHT : gsgd_pkg::GEST_RIGHT;
         default:
            code = gsgd_pkg::GEST_DOWN;
      endcase
   end

   // Hold the classify step while a result must go out and the output
   // register is still occupied.
   assign commit = (state_ff == gsgd_pkg::ST_DONE) &&
                   !(emit && rsp_valid_ff && rsp_stall);

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      scan_cnt_in   = scan_cnt_ff;
      write_slot_in = write_slot_ff;
      pending_in    = pending_ff;
      sample_in     = sample_ff;
      dbl_in        = dbl_ff;
      gesture_in    = gesture_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      req_stall     = (state_ff != gsgd_pkg::ST_IDLE);

      unique case (state_ff)
         gsgd_pkg::ST_IDLE: begin
            if (req_valid) begin
               sample_in.pitch = req_pitch_rate;
               sample_in.yaw   = req_yaw_rate;
               dbl_in          = req_double_held;
               scan_cnt_in     = '0;
               state_in        = gsgd_pkg::ST_SCAN;
            end
         end
         gsgd_pkg::ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == SW'(W - 1)) begin
               state_in = gsgd_pkg::ST_DONE;
            end
         end
         gsgd_pkg::ST_DONE: begin
            if (commit) begin
               pending_in    = move_cls;
               write_slot_in = (write_slot_ff == SW'(W - 1)) ? '0
                               : write_slot_ff + 1'b1;
               if (emit) begin
                  gesture_in   = code;
                  rsp_valid_in = 1'b1;
               end
               state_in = gsgd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gsgd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gsgd_pkg::ST_IDLE;
         scan_cnt_ff   <= '0;
         write_slot_ff <= '0;
         pending_ff    <= gsgd_pkg::MOVE_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_cnt_ff   <= scan_cnt_in;
         write_slot_ff <= write_slot_in;
         pending_ff    <= pending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      dbl_ff     <= dbl_in;
      gesture_ff <= gesture_in;
   end

   // threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         down_thr_ff <= gsgd_pkg::DOWN_THR_RESET;
         side_thr_ff <= gsgd_pkg::SIDE_THR_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            gsgd_pkg::CSR_DOWN_THRESHOLD: down_thr_ff <= csr_wdata;
            gsgd_pkg::CSR_SIDE_THRESHOLD: side_thr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_gesture = gesture_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      write_slot_ff <= SW'(W - 1))
      else $error("write slot beyond ring");

   a_scan_to_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gsgd_pkg::ST_SCAN && scan_cnt_ff == SW'(W - 1))
      |=> state_ff == gsgd_pkg::ST_DONE)
      else $error("scan did not finish after a full rotation");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (commit && emit) |=> rsp_valid_ff)
      else $error("emitted gesture not presented");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == gsgd_pkg::ST_DONE)
      else $error("result appeared outside the classify step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && state_ff == gsgd_pkg::ST_DONE && emit)
      |=> state_ff == gsgd_pkg::ST_DONE)
      else $error("held gesture would be overwritten");

endmodule

### bench/gyro_swing_gesture_detector_test.sv
// Self-checking bench for the gyro swing gesture detector: random swing
// sequences, threshold sweeps, a shadow window/classifier and a gesture scoreboard.
// Depends on gsgd_pkg and the gyro_swing_gesture_detector RTL.
`timescale 1ns / 100ps

module gyro_swing_gesture_detector_test;

   localparam int WINDOW = gsgd_pkg::WINDOW;
   localparam int RATE_W = gsgd_pkg::RATE_W;
   localparam int THR_W  = gsgd_pkg::THR_W;
   localparam int GEST_W = gsgd_pkg::GEST_W;

   // settle time after the last expected gesture
   localparam int SETTLE_CYCLES = 2 * (WINDOW + 2) + 4;
   localparam int DRAIN_LIMIT   = 4000;
   localparam int RATE_MAX      = 32767;

   typedef struct {
      logic signed [RATE_W-1:0] pitch;
      logic signed [RATE_W-1:0] yaw;
      logic                     held;
   } gyro_sample_type;

   // clock, reset and DUT ports; every input starts at a known value
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [RATE_W-1:0] req_pitch_rate = '0;
   logic signed [RATE_W-1:0] req_yaw_rate = '0;
   logic                     req_double_held = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [GEST_W-1:0]        rsp_gesture;
   logic                     csr_wr_en = 1'b0;
   logic                     csr_index = gsgd_pkg::CSR_DOWN_THRESHOLD;
   logic [THR_W-1:0]         csr_wdata = '0;

   // shadow copy of the detector: sample rings, write slot, pending move, thresholds
   logic signed [RATE_W-1:0] pitch_ring [WINDOW] = '{default: '0};
   logic signed [RATE_W-1:0] yaw_ring [WINDOW] = '{default: '0};
   int                       ring_slot = 0;
   gsgd_pkg::move_type       pending_move = gsgd_pkg::MOVE_NONE;
   logic [THR_W-1:0]         down_thr = gsgd_pkg::DOWN_THR_RESET;
   logic [THR_W-1:0]         side_thr = gsgd_pkg::SIDE_THR_RESET;

   gyro_sample_type       sample_queue [$];   // samples waiting to be offered
   gsgd_pkg::gesture_type gesture_queue [$];  // gestures the block still owes us
   gyro_sample_type       taken_sample;
   gsgd_pkg::gesture_type expected_gesture;

   int gap_pct = 6;
   int stall_pct = 6;
   int mismatches = 0;
   int samples_taken = 0;
   int gestures_checked = 0;
   int settings_run = 1;
   int gesture_count [5] = '{default: 0};

   gyro_swing_gesture_detector u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pitch_rate  (req_pitch_rate),
      .req_yaw_rate    (req_yaw_rate),
      .req_double_held (req_double_held),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_gesture     (rsp_gesture),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // full magnitude, so that -32768 counts as 32768
   function automatic int magnitude(input logic signed [RATE_W-1:0] v);
      int w;
      w = v;
      return (w < 0) ? -w : w;
   endfunction

   // Advance the shadow detector by one sample. Scan the window as it stood
   // before the sample, classify, queue a gesture when motion ends, then
   // write the sample into its slot.
   task automatic track_swing(input gyro_sample_type s);
      logic signed [RATE_W-1:0] pitch_peak;
      logic signed [RATE_W-1:0] yaw_peak;
      gsgd_pkg::gesture_type    g;
      pitch_peak = '0;
      yaw_peak = '0;
      // strictly larger magnitude replaces the peak, so the earliest entry wins ties
      for (int i = 0; i < WINDOW; i++) begin
         if (magnitude(pitch_ring[i]) > magnitude(pitch_peak)) pitch_peak = pitch_ring[i];
         if (magnitude(yaw_ring[i]) > magnitude(yaw_peak)) yaw_peak = yaw_ring[i];
      end
      if (magnitude(pitch_peak) > magnitude(yaw_peak) && int'(pitch_peak) > int'(down_thr)) begin
         pending_move = gsgd_pkg::MOVE_DOWN;
      end else if (magnitude(yaw_peak) > int'(side_thr)) begin
         // a side swing locks its direction until the motion ends
         if (int'(yaw_peak) > 0 && pending_move != gsgd_pkg::MOVE_RIGHT) begin
            pending_move = gsgd_pkg::MOVE_LEFT;
         end else if (pending_move != gsgd_pkg::MOVE_LEFT) begin
            pending_move = gsgd_pkg::MOVE_RIGHT;
         end
      end else begin
         // motion over: emit the pending move, doubled if the button is held
         if (pending_move != gsgd_pkg::MOVE_NONE) begin
            if (s.held) begin
               g = (pending_move == gsgd_pkg::MOVE_DOWN) ? gsgd_pkg::GEST_DOUBLE_CENTER
                                                         : gsgd_pkg::GEST_LEFT_RIGHT;
            end else begin
               case (pending_move)
                  gsgd_pkg::MOVE_DOWN: g = gsgd_pkg::GEST_DOWN;
                  gsgd_pkg::MOVE_LEFT: g = gsgd_pkg::GEST_LEFT;
                  default:             g = gsgd_pkg::GEST_RIGHT;
               endcase
            end
            gesture_queue.push_back(g);
         end
         pending_move = gsgd_pkg::MOVE_NONE;
      end
      pitch_ring[ring_slot] = s.pitch;
      yaw_ring[ring_slot] = s.yaw;
      ring_slot = (ring_slot + 1) % WINDOW;
   endtask

   // Driver: hold a stalled transfer, otherwise offer the next sample or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            taken_sample.pitch = req_pitch_rate;
            taken_sample.yaw = req_yaw_rate;
            taken_sample.held = req_double_held;
            track_swing(taken_sample);
            samples_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (sample_queue.size() != 0 && int'($urandom_range(99)) >= gap_pct) begin
               taken_sample = sample_queue.pop_front();
               req_valid <= 1'b1;
               req_pitch_rate <= taken_sample.pitch;
               req_yaw_rate <= taken_sample.yaw;
               req_double_held <= taken_sample.held;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare every gesture transfer with the oldest expectation,
   // and throttle the gesture channel at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (gesture_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: gesture %0d arrived with none expected", $time, rsp_gesture);
            end else begin
               expected_gesture = gesture_queue.pop_front();
               gestures_checked++;
               gesture_count[expected_gesture]++;
               if (rsp_gesture !== expected_gesture) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: gesture mismatch, expected %0d (%s), got %0d", $time,
                              expected_gesture, expected_gesture.name(), rsp_gesture);
               end
            end
         end
         rsp_stall <= (int'($urandom_range(99)) < stall_pct);
      end
   end

   function automatic int rand_between(input int lo, input int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // a sample that stays at or under both thresholds, often well under
   function automatic gyro_sample_type quiet_sample();
      gyro_sample_type s;
      int              pitch_bound;
      int              yaw_bound;
      pitch_bound = int'(down_thr);
      yaw_bound = int'(side_thr);
      if ($urandom_range(1)) begin
         pitch_bound = pitch_bound / 4;
         yaw_bound = yaw_bound / 4;
      end
      s.pitch = RATE_W'(rand_between(-pitch_bound, pitch_bound));
      s.yaw = RATE_W'(rand_between(-yaw_bound, yaw_bound));
      s.held = 1'($urandom_range(1));
      return s;
   endfunction

   // kind: 0 down, 1 left, 2 right, otherwise anything at all
   function automatic gyro_sample_type swing_sample(input int kind);
      gyro_sample_type s;
      int              pitch_lo;
      int              yaw_lo;
      pitch_lo = (int'(down_thr) < RATE_MAX) ? int'(down_thr) + 1 : RATE_MAX;
      yaw_lo = (int'(side_thr) < RATE_MAX) ? int'(side_thr) + 1 : RATE_MAX;
      s = quiet_sample();
      case (kind)
         0: s.pitch = RATE_W'(rand_between(pitch_lo, RATE_MAX));
         1: s.yaw = RATE_W'(rand_between(yaw_lo, RATE_MAX));
         2: s.yaw = ($urandom_range(7) == 0) ? 16'sh8000 :
                    RATE_W'(-rand_between(yaw_lo, RATE_MAX));
         default: begin
            s.pitch = RATE_W'($urandom);
            s.yaw = RATE_W'($urandom);
         end
      endcase
      return s;
   endfunction

   task automatic add_sample(input int pitch, input int yaw, input logic held);
      gyro_sample_type s;
      s.pitch = RATE_W'(pitch);
      s.yaw = RATE_W'(yaw);
      s.held = held;
      sample_queue.push_back(s);
   endtask

   // Fill the queue until it holds at least 'total' samples: mostly whole
   // swings (lead-in, one to three swing samples, a quiet tail long enough
   // to flush the window), some cut short, plus raw noise.
   task automatic plan_swings(input int total);
      gyro_sample_type s;
      int              kind;
      int              tail;
      while (sample_queue.size() < total) begin
         if ($urandom_range(99) < 15) begin
            s.pitch = RATE_W'($urandom);
            s.yaw = RATE_W'($urandom);
            s.held = 1'($urandom_range(1));
            sample_queue.push_back(s);
         end else begin
            kind = int'($urandom_range(3));
            repeat ($urandom_range(2)) sample_queue.push_back(quiet_sample());
            repeat (1 + $urandom_range(2)) begin
               // now and then switch direction mid-swing to probe the lock
               if ($urandom_range(99) < 30) kind = int'($urandom_range(3));
               sample_queue.push_back(swing_sample(kind));
            end
            tail = ($urandom_range(99) < 20) ? rand_between(1, WINDOW) :
                                               rand_between(WINDOW + 1, WINDOW + 3);
            repeat (tail) sample_queue.push_back(quiet_sample());
         end
      end
   endtask

   // Wait for every sample to be taken and, up to a wait limit, for every
   // gesture to arrive, then let a sample in flight finish before touching the registers.
   task automatic drain();
      int waited;
      waited = 0;
      while (sample_queue.size() != 0 || req_valid) @(posedge clock);
      while (gesture_queue.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_threshold(input gsgd_pkg::csr_index_type idx,
                                input logic [THR_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == gsgd_pkg::CSR_DOWN_THRESHOLD) down_thr = value;
      else side_thr = value;
   endtask

   // One threshold setting: write both registers, then run random swings.
   task automatic run_phase(input logic [THR_W-1:0] down_value,
                            input logic [THR_W-1:0] side_value,
                            input int count, input int gaps);
      set_threshold(gsgd_pkg::CSR_DOWN_THRESHOLD, down_value);
      set_threshold(gsgd_pkg::CSR_SIDE_THRESHOLD, side_value);
      settings_run++;
      @(negedge clock);
      gap_pct = gaps;
      stall_pct = gaps;
      plan_swings(count);
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed run at the reset thresholds (900 / 500 deg/s).
      @(negedge clock);
      // quiet window with nothing pending: no gesture
      add_sample(0, 0, 1'b0);
      // full-scale extremes; negative pitch peak of -32768 outweighs yaw but is no down swing
      add_sample(-32768, 32767, 1'b0);
      add_sample(32767, -32767, 1'b0);
      // left locks: equal yaw magnitudes keep the first (positive) peak, and once
      // the positive one leaves the window the negative peak must not turn it right;
      // the ending sample holds the button, so expect left plus right
      repeat (WINDOW + 1) add_sample(0, 0, 1'b1);
      // pitch one above the down threshold, then samples exactly at both
      // thresholds, which must count as quiet; ends as a plain down gesture
      add_sample(14401, 14400, 1'b0);
      repeat (WINDOW + 1) add_sample(14400, 8000, 1'b0);
      plan_swings(250);
      drain();

      // thresholds at zero: any nonzero yaw peak or positive pitch peak is a swing
      run_phase('0, '0, 120, 6);
      // thresholds at full scale: only a yaw of -32768 can exceed them
      run_phase('1, '1, 120, 6);
      // long stretch with no idling on either side
      run_phase(THR_W'(rand_between(2000, 20000)), THR_W'(rand_between(2000, 20000)), 200, 0);
      run_phase(THR_W'($urandom_range(32767)), THR_W'($urandom_range(32767)), 230, 6);

      if (gesture_queue.size() != 0) begin
         $display("%0d expected gestures never arrived", gesture_queue.size());
         mismatches += gesture_queue.size();
      end
      $display("Ran %0d gyro samples over %0d threshold settings, %0d gestures checked",
               samples_taken, settings_run, gestures_checked);
      $display("  down %0d, left %0d, right %0d, double center %0d, left plus right %0d",
               gesture_count[gsgd_pkg::GEST_DOWN], gesture_count[gsgd_pkg::GEST_LEFT],
               gesture_count[gsgd_pkg::GEST_RIGHT],
               gesture_count[gsgd_pkg::GEST_DOUBLE_CENTER],
               gesture_count[gsgd_pkg::GEST_LEFT_RIGHT]);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("TB_ERROR");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #400000;
      $display("run timed out");
      $display("TB_ERROR");
      $finish;
   end

endmodule

### sim.f
hdl/gsgd_pkg.sv
hdl/gsgd_cell.sv
hdl/gsgd_peak.sv
hdl/gyro_swing_gesture_detector.sv
bench/gyro_swing_gesture_detector_test.sv
